// ----- src/gazs_pkg.sv -----
// ----------------------------------------------------------------------------
// gazs_pkg: shared types and constants for gyro average, zero and scale
// Sequencer state type, register index codes and fixed field widths.
// ----------------------------------------------------------------------------
package gazs_pkg;

   localparam int SUM_W   = 15;  // roll/pitch sum width
   localparam int COUNT_W = 6;   // sample count width
   localparam int QUO_W   = 16;  // dividend and quotient width
   localparam int WORD_W  = 16;  // zero point and accumulator width
   localparam int BYTE_W  = 8;
   localparam int FINE_W  = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CROSS_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_TYPE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_TRIMS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_TRIM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_TRIM  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROTATE,
      ST_APPLY,
      ST_FINAL
   } state_type;

endpackage

// ----- src/gyro_average_zero_and_scale.sv -----
// ----------------------------------------------------------------------------
// gyro_average_zero_and_scale: gyro averaging, auto-zero and rate scaling
// Per frame averages roll/pitch sums, calibrates zero points and scales rates.
// ----------------------------------------------------------------------------
// One request per control frame; a new request is stalled until the block is
// idle again. A request passes through one shared restoring divider that
// makes one quotient bit per cycle (roll average, then pitch average), then
// cross rotation, zero subtraction or calibration accumulation, and final
// scaling into the result register. The final step waits while the previous
// result is still stalled. The user must write configuration registers through
// the csr port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gyro_average_zero_and_scale #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [gazs_pkg::SUM_W-1:0]           req_roll_sum,
   input  logic [gazs_pkg::SUM_W-1:0]           req_pitch_sum,
   input  logic [gazs_pkg::COUNT_W-1:0]         req_sample_count,
   input  logic [gazs_pkg::BYTE_W-1:0]          req_yaw_sample,
   input  logic [gazs_pkg::BYTE_W-1:0]          req_calib_count,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [gazs_pkg::BYTE_W-1:0]   rsp_roll_pd,
   output logic signed [gazs_pkg::BYTE_W-1:0]   rsp_pitch_pd,
   output logic signed [gazs_pkg::FINE_W-1:0]   rsp_roll_fine,
   output logic signed [gazs_pkg::FINE_W-1:0]   rsp_pitch_fine,
   output logic signed [gazs_pkg::BYTE_W-1:0]   rsp_yaw_rate,
   output logic                                 rsp_calibrating,
   // configuration port
   input  logic                                 csr_write_enable,
   input  logic [gazs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gazs_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import gazs_pkg::*;

   localparam int DIV_W = $clog2(MAX_SAMPLES + 1);
   localparam int CNT_W = $clog2(QUO_W);
   localparam logic [DIV_W-1:0] MAX_N = DIV_W'(MAX_SAMPLES);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

   // configuration
   logic              cross_mode_ff, sensor_type_ff, skip_trims_ff;
   logic [BYTE_W-1:0] roll_trim_ff, pitch_trim_ff;

   // persistent state
   logic [WORD_W-1:0] roll_zero_ff, roll_zero_in;
   logic [WORD_W-1:0] pitch_zero_ff, pitch_zero_in;
   logic [WORD_W-1:0] roll_acc_ff, roll_acc_in;
   logic [WORD_W-1:0] pitch_acc_ff, pitch_acc_in;
   logic [BYTE_W-1:0] yaw_zero_ff, yaw_zero_in;

   // sequencer and request holding
   state_type         state_ff, state_in;
   logic [SUM_W-1:0]  pitch_sum_ff, pitch_sum_in;
   logic [DIV_W-1:0]  half_ff, half_in;
   logic [BYTE_W-1:0] yaw_ff, yaw_in;
   logic [BYTE_W-1:0] cal_ff, cal_in;

   // shared divider
   logic [DIV_W-1:0]  div_n_ff, div_n_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic              div_axis_ff, div_axis_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    trial_diff;
   logic              trial_ge;
   logic [QUO_W-1:0]  quo_next;

   // averages, later the zero-corrected differences
   logic [WORD_W-1:0] roll_val_ff, roll_val_in;
   logic [WORD_W-1:0] pitch_val_ff, pitch_val_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [BYTE_W-1:0]  roll_pd_ff, roll_pd_in;
   logic signed [BYTE_W-1:0]  pitch_pd_ff, pitch_pd_in;
   logic signed [FINE_W-1:0]  roll_fine_ff, roll_fine_in;
   logic signed [FINE_W-1:0]  pitch_fine_ff, pitch_fine_in;
   logic signed [BYTE_W-1:0]  yaw_rate_ff, yaw_rate_in;
   logic                      calib_ff, calib_in;

   logic              req_accept;
   logic              rsp_free;
   logic [DIV_W-1:0]  n_eff;
   logic [DIV_W-1:0]  n_half;
   logic [BYTE_W-1:0] yaw_zero_use;
   logic [WORD_W-1:0] roll_trim_add, pitch_trim_add;
   logic [WORD_W-1:0] roll_cal_sum, pitch_cal_sum;
   logic [BYTE_W-1:0] roll_pd_s, pitch_pd_s;
   logic [FINE_W-1:0] roll_fine_s, pitch_fine_s;

   function automatic logic [FINE_W-1:0] sat_fine(input logic [WORD_W-1:0] x);
      logic [FINE_W-1:0] r;
      if (x[WORD_W-1] == 1'b0 && x[WORD_W-2:FINE_W-1] != '0) begin
         r = {1'b0, {(FINE_W-1){1'b1}}};
      end else if (x[WORD_W-1] == 1'b1 && x[WORD_W-2:FINE_W-1] != '1) begin
         r = {1'b1, {(FINE_W-1){1'b0}}};
      end else begin
         r = x[FINE_W-1:0];
      end
      return r;
   endfunction

   // pd keeps low 8 bits of the scaled value, fine saturates to 12 bits
   function automatic logic [BYTE_W+FINE_W-1:0] scale_axis(
      input logic [WORD_W-1:0] d,
      input logic              sensor
   );
      logic [WORD_W-1:0] d1;
      logic [WORD_W-1:0] d2;
      logic [BYTE_W-1:0] pd;
      logic [FINE_W-1:0] fine;
      d1 = d + WORD_W'(1);
      d2 = d + WORD_W'(2);
      if (!sensor) begin
         pd   = d2[BYTE_W+1:2];
         fine = sat_fine({d1[WORD_W-1], d1[WORD_W-1:1]});
      end else begin
         pd   = d1[BYTE_W:1];
         fine = sat_fine(d);
      end
      return {pd, fine};
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // divisor: zero count divides by one, large counts clamp
   always_comb begin
      if (req_sample_count == '0) begin
         n_eff = DIV_W'(1);
      end else if (int'(req_sample_count) > MAX_SAMPLES) begin
         n_eff = MAX_N;
      end else begin
         n_eff = DIV_W'(req_sample_count);
      end
      n_half = n_eff >> 1;
   end

   // one restoring divide step
   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_diff = trial - {1'b0, div_n_ff};
   assign trial_ge   = (trial >= {1'b0, div_n_ff});
   assign quo_next   = {quo_ff[QUO_W-2:0], trial_ge};

   assign yaw_zero_use   = (yaw_zero_ff == '0) ? yaw_ff : yaw_zero_ff;
   assign roll_trim_add  = skip_trims_ff ? '0 : {{(WORD_W-BYTE_W){roll_trim_ff[BYTE_W-1]}},
                                                 roll_trim_ff};
   assign pitch_trim_add = skip_trims_ff ? '0 : {{(WORD_W-BYTE_W){pitch_trim_ff[BYTE_W-1]}},
                                                 pitch_trim_ff};
   assign roll_cal_sum   = roll_acc_ff + WORD_W'(16) + roll_trim_add;
   assign pitch_cal_sum  = pitch_acc_ff + WORD_W'(16) + pitch_trim_add;
   assign {roll_pd_s, roll_fine_s}   = scale_axis(roll_val_ff, sensor_type_ff);
   assign {pitch_pd_s, pitch_fine_s} = scale_axis(pitch_val_ff, sensor_type_ff);

   always_comb begin
      state_in      = state_ff;
      pitch_sum_in  = pitch_sum_ff;
      half_in       = half_ff;
      yaw_in        = yaw_ff;
      cal_in        = cal_ff;
      div_n_in      = div_n_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      div_axis_in   = div_axis_ff;
      roll_val_in   = roll_val_ff;
      pitch_val_in  = pitch_val_ff;
      roll_zero_in  = roll_zero_ff;
      pitch_zero_in = pitch_zero_ff;
      roll_acc_in   = roll_acc_ff;
      pitch_acc_in  = pitch_acc_ff;
      yaw_zero_in   = yaw_zero_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      roll_pd_in    = roll_pd_ff;
      pitch_pd_in   = pitch_pd_ff;
      roll_fine_in  = roll_fine_ff;
      pitch_fine_in = pitch_fine_ff;
      yaw_rate_in   = yaw_rate_ff;
      calib_in      = calib_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pitch_sum_in = req_pitch_sum;
               half_in      = n_half;
               yaw_in       = req_yaw_sample;
               cal_in       = req_calib_count;
               div_n_in     = n_eff;
               rem_in       = '0;
               quo_in       = QUO_W'(req_roll_sum) + QUO_W'(n_half);
               div_cnt_in   = '0;
               div_axis_in  = 1'b0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in     = quo_next;
            div_cnt_in = div_cnt_ff + CNT_W'(1);
            if (div_cnt_ff == LAST_STEP) begin
               rem_in = '0;
               if (!div_axis_ff) begin
                  roll_val_in = quo_next;
                  quo_in      = QUO_W'(pitch_sum_ff) + QUO_W'(half_ff);
                  div_axis_in = 1'b1;
               end else begin
                  pitch_val_in = quo_next;
                  state_in     = ST_ROTATE;
               end
            end
         end
         ST_ROTATE: begin
            if (cross_mode_ff) begin
               roll_val_in  = roll_val_ff + pitch_val_ff;
               pitch_val_in = roll_val_ff - pitch_val_ff;
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (cal_ff != '0) begin
               roll_acc_in  = roll_acc_ff + roll_val_ff;
               pitch_acc_in = pitch_acc_ff + pitch_val_ff;
            end else begin
               roll_val_in  = roll_val_ff - roll_zero_ff;
               pitch_val_in = pitch_val_ff - pitch_zero_ff;
            end
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (cal_ff != '0) begin
                  roll_pd_in    = '0;
                  pitch_pd_in   = '0;
                  roll_fine_in  = '0;
                  pitch_fine_in = '0;
                  yaw_rate_in   = '0;
                  calib_in      = 1'b1;
                  // last calibration frame closes the average over 32 frames
                  if (cal_ff == BYTE_W'(1)) begin
                     roll_zero_in  = {5'd0, roll_cal_sum[WORD_W-1:5]};
                     pitch_zero_in = {5'd0, pitch_cal_sum[WORD_W-1:5]};
                     roll_acc_in   = '0;
                     pitch_acc_in  = '0;
                  end
               end else begin
                  roll_pd_in    = roll_pd_s;
                  pitch_pd_in   = pitch_pd_s;
                  roll_fine_in  = roll_fine_s;
                  pitch_fine_in = pitch_fine_s;
                  // yaw zero captured on first nonzero flight sample
                  yaw_zero_in   = yaw_zero_use;
                  yaw_rate_in   = yaw_ff - yaw_zero_use;
                  calib_in      = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cross_mode_ff  <= 1'b0;
         sensor_type_ff <= 1'b0;
         skip_trims_ff  <= 1'b0;
         roll_trim_ff   <= '0;
         pitch_trim_ff  <= '0;
         roll_zero_ff   <= '0;
         pitch_zero_ff  <= '0;
         roll_acc_ff    <= '0;
         pitch_acc_ff   <= '0;
         yaw_zero_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         roll_zero_ff  <= roll_zero_in;
         pitch_zero_ff <= pitch_zero_in;
         roll_acc_ff   <= roll_acc_in;
         pitch_acc_ff  <= pitch_acc_in;
         yaw_zero_ff   <= yaw_zero_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CROSS_MODE:  cross_mode_ff  <= csr_write_data[0];
               CSR_SENSOR_TYPE: sensor_type_ff <= csr_write_data[0];
               CSR_SKIP_TRIMS:  skip_trims_ff  <= csr_write_data[0];
               CSR_ROLL_TRIM:   roll_trim_ff   <= csr_write_data;
               CSR_PITCH_TRIM:  pitch_trim_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pitch_sum_ff  <= pitch_sum_in;
      half_ff       <= half_in;
      yaw_ff        <= yaw_in;
      cal_ff        <= cal_in;
      div_n_ff      <= div_n_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      div_axis_ff   <= div_axis_in;
      roll_val_ff   <= roll_val_in;
      pitch_val_ff  <= pitch_val_in;
      roll_pd_ff    <= roll_pd_in;
      pitch_pd_ff   <= pitch_pd_in;
      roll_fine_ff  <= roll_fine_in;
      pitch_fine_ff <= pitch_fine_in;
      yaw_rate_ff   <= yaw_rate_in;
      calib_ff      <= calib_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_pd     = roll_pd_ff;
   assign rsp_pitch_pd    = pitch_pd_ff;
   assign rsp_roll_fine   = roll_fine_ff;
   assign rsp_pitch_fine  = pitch_fine_ff;
   assign rsp_yaw_rate    = yaw_rate_ff;
   assign rsp_calibrating = calib_ff;

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_DIV && div_cnt_ff == '0 && !div_axis_ff))
      else $error("divider not started cleanly after request");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (rem_ff < div_n_ff && div_n_ff != '0))
      else $error("divider remainder out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINAL)
      else $error("response raised outside final step");

   a_cal_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && calib_ff) |-> (roll_pd_ff == '0 && pitch_pd_ff == '0 &&
         roll_fine_ff == '0 && pitch_fine_ff == '0 && yaw_rate_ff == '0))
      else $error("calibration response carries nonzero rates");

endmodule
